// ===== src/pps_pkg.sv =====
// shared types and constants for the preemptive priority scheduler
`timescale 1ns / 1ps

package pps_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int ARR_W  = 16;
  localparam int REM_W  = 16;
  localparam int URG_W  = 8;
  localparam int TIME_W = 32;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_en;
    logic scan_start;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

// ===== src/pps_ctrl.sv =====
// controller state machine: load, scan and commit sequencing
`timescale 1ns / 1ps

module pps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tuser,
  input  logic              m_tready,
  input  pps_pkg::status_t  status,
  output pps_pkg::cmd_t     cmd
);

  pps_pkg::state_t state;
  pps_pkg::state_t state_next;
  logic            can_commit;

  assign can_commit = !status.out_busy || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pps_pkg::ST_IDLE: begin
        if (s_tvalid && s_tuser == pps_pkg::OP_TICK) begin
          state_next = pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = pps_pkg::ST_FINISH;
        end
      end
      pps_pkg::ST_FINISH: begin
        if (can_commit) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd.load_en    = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.commit     = 1'b0;
    case (state)
      pps_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.load_en    = s_tvalid && s_tuser == pps_pkg::OP_LOAD;
        cmd.scan_start = s_tvalid && s_tuser == pps_pkg::OP_TICK;
      end
      pps_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      pps_pkg::ST_FINISH: begin
        cmd.commit = can_commit;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/pps_dp.sv =====
// datapath: slot table, sequential best-slot scan, clock and result register
`timescale 1ns / 1ps

module pps_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [pps_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [pps_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tuser,
  input  pps_pkg::cmd_t                      cmd,
  output pps_pkg::status_t                   status
);

  logic [pps_pkg::SLOTS-1:0]  slot_valid;
  logic [pps_pkg::ARR_W-1:0]  slot_arrival   [pps_pkg::SLOTS];
  logic [pps_pkg::REM_W-1:0]  slot_remaining [pps_pkg::SLOTS];
  logic [pps_pkg::URG_W-1:0]  slot_urgency   [pps_pkg::SLOTS];
  logic [pps_pkg::TIME_W-1:0] clock_time;

  logic [pps_pkg::SLOT_W-1:0] scan_idx;
  logic                       found;
  logic [pps_pkg::SLOT_W-1:0] best_idx;
  logic [pps_pkg::URG_W-1:0]  best_urg;
  logic [pps_pkg::ARR_W-1:0]  best_arr;
  logic [pps_pkg::REM_W-1:0]  best_rem;
  logic [pps_pkg::CNT_W-1:0]  live_cnt;

  logic [3:0]                 in_slot;
  logic [pps_pkg::ARR_W-1:0]  in_arrival;
  logic [pps_pkg::REM_W-1:0]  in_burst;
  logic [pps_pkg::URG_W-1:0]  in_urgency;
  logic                       in_range;
  logic [pps_pkg::SLOT_W-1:0] wr_idx;

  logic                       rd_valid;
  logic [pps_pkg::ARR_W-1:0]  rd_arr;
  logic [pps_pkg::REM_W-1:0]  rd_rem;
  logic [pps_pkg::URG_W-1:0]  rd_urg;
  logic                       rd_live;
  logic                       rd_ready;
  logic                       rd_better;

  logic [pps_pkg::TIME_W-1:0] clock_next;
  logic                       done_now;
  logic                       all_done;

  assign in_slot    = s_tdata[3:0];
  assign in_arrival = s_tdata[19:4];
  assign in_burst   = s_tdata[35:20];
  assign in_urgency = s_tdata[43:36];
  assign in_range   = 32'(in_slot) < pps_pkg::SLOTS;
  assign wr_idx     = pps_pkg::SLOT_W'(in_slot);

  assign rd_valid  = slot_valid[scan_idx];
  assign rd_arr    = slot_arrival[scan_idx];
  assign rd_rem    = slot_remaining[scan_idx];
  assign rd_urg    = slot_urgency[scan_idx];
  assign rd_live   = rd_valid && rd_rem != '0;
  assign rd_ready  = rd_live && pps_pkg::TIME_W'(rd_arr) <= clock_time;
  assign rd_better = !found || rd_urg < best_urg || (rd_urg == best_urg && rd_arr < best_arr);

  assign clock_next = (clock_time == '1) ? clock_time : clock_time + pps_pkg::TIME_W'(1);
  assign done_now   = found && best_rem == pps_pkg::REM_W'(1);
  assign all_done   = live_cnt == '0 || (live_cnt == pps_pkg::CNT_W'(1) && done_now);

  assign status.scan_last = scan_idx == pps_pkg::SLOT_W'(pps_pkg::SLOTS - 1);
  assign status.out_busy  = m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      clock_time <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.load_en && in_range) begin
        slot_valid[wr_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        clock_time <= clock_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // slot table payload
  always_ff @(posedge clk) begin
    if (cmd.load_en && in_range) begin
      slot_arrival[wr_idx]   <= in_arrival;
      slot_remaining[wr_idx] <= in_burst;
      slot_urgency[wr_idx]   <= in_urgency;
    end else if (cmd.commit && found) begin
      slot_remaining[best_idx] <= best_rem - pps_pkg::REM_W'(1);
    end
  end

  // scan over slots, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      found    <= 1'b0;
      live_cnt <= '0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      found    <= 1'b0;
      live_cnt <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + pps_pkg::SLOT_W'(1);
      if (rd_live) begin
        live_cnt <= live_cnt + pps_pkg::CNT_W'(1);
      end
      if (rd_ready && rd_better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_ready && rd_better) begin
      best_idx <= scan_idx;
      best_urg <= rd_urg;
      best_arr <= rd_arr;
      best_rem <= rd_rem;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata[31:0]  <= clock_next;
      m_tdata[35:32] <= found ? 4'(best_idx) : 4'd0;
      m_tdata[36]    <= done_now;
      m_tdata[37]    <= all_done;
      m_tdata[39:38] <= 2'b00;
      m_tuser        <= !found;
    end
  end

endmodule

// ===== src/preemptive_priority_scheduler_core.sv =====
// top level of the preemptive priority scheduler
`timescale 1ns / 1ps
//
// input stream: a load beat (tuser low) writes one task slot with its arrival
// time, burst and urgency and marks it valid; a tick beat (tuser high) runs
// one time step. lower urgency wins, ties go to earlier arrival, then lower slot.
// a load gives no output beat. a tick scans the 16 slots, one slot per cycle
// through the slot table read port, then commits: the chosen slot loses one
// unit of work and time advances, saturating at its max. each tick gives
// exactly one output beat; the input is ready again in the cycle that beat
// first turns valid, so no new beat is taken while a tick is in progress,
// and loads run at one per cycle.
// the result sits in an output register, so loads and the next tick's scan
// go on while the receiver stalls; a tick only waits at its commit while the
// previous result has not been taken.
// reset clears all slot valid bits, the time and the output valid; the block
// is ready in the cycle after reset is released.
//

module preemptive_priority_scheduler_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // slot[3:0], arrival[19:4], burst[35:20], urgency[43:36], zero fill
  input  logic [pps_pkg::IN_DATA_W-1:0]      s_tdata,
  // operation
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // time_now[31:0], chosen_slot[35:32], finished[36], all_done[37], zero fill
  output logic [pps_pkg::OUT_DATA_W-1:0]     m_tdata,
  // idle
  output logic                               m_tuser
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pps_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
